@@ hdl/affine_transform_stack_macros.svh @@
// Assertion macros for the affine transform stack
`ifndef AFFINE_TRANSFORM_STACK_MACROS_SVH
`define AFFINE_TRANSFORM_STACK_MACROS_SVH

// same-cycle implication
`define ATS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ATS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/ats_pkg.sv @@
// Shared types, codes and helper functions of the affine transform stack
package ats_pkg;

    typedef enum logic [2:0] {
        CMD_IDENTITY  = 3'd0,
        CMD_TRANSLATE = 3'd1,
        CMD_ROTATE    = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_SHEAR     = 3'd4,
        CMD_PUSH      = 3'd5,
        CMD_POP       = 3'd6,
        CMD_POINT     = 3'd7
    } cmd_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd1;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd2;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 4'd1;

    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;

    typedef struct packed {
        logic init;
        logic mul;
        logic acc;
    } mac_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7FFF;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h3243F6A8;
            5'd1:    r = 32'h1DAC6705;
            5'd2:    r = 32'h0FADBAFC;
            5'd3:    r = 32'h07F56EA6;
            5'd4:    r = 32'h03FEAB76;
            5'd5:    r = 32'h01FFD55B;
            5'd6:    r = 32'h00FFFAAA;
            5'd7:    r = 32'h007FFF55;
            5'd8:    r = 32'h003FFFEA;
            5'd9:    r = 32'h001FFFFD;
            5'd10:   r = 32'h000FFFFF;
            5'd11:   r = 32'h0007FFFF;
            5'd12:   r = 32'h0003FFFF;
            5'd13:   r = 32'h0001FFFF;
            5'd14:   r = 32'h0000FFFF;
            5'd15:   r = 32'h00007FFF;
            5'd16:   r = 32'h00003FFF;
            5'd17:   r = 32'h00001FFF;
            5'd18:   r = 32'h00000FFF;
            5'd19:   r = 32'h000007FF;
            5'd20:   r = 32'h000003FF;
            5'd21:   r = 32'h000001FF;
            5'd22:   r = 32'h000000FF;
            5'd23:   r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/ats_if.sv @@
// Channel interfaces: command input, result output, configuration write
interface ats_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface ats_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    logic signed [31:0] mat_tx;
    logic signed [31:0] mat_ty;
    logic [5:0]         depth_now;
    logic [1:0]         status;
    modport source (output valid, point_x, point_y, mat_a, mat_b, mat_c, mat_d,
                    mat_tx, mat_ty, depth_now, status, input ready);
    modport sink   (input valid, point_x, point_y, mat_a, mat_b, mat_c, mat_d,
                    mat_tx, mat_ty, depth_now, status, output ready);
endinterface

interface ats_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ats_mac.sv @@
// Shared multiplier with floor-shifted accumulator
module ats_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  ats_pkg::mac_ctrl_t    ctrl,
    input  logic signed [31:0]    op_l,
    input  logic signed [31:0]    op_r,
    input  logic signed [63:0]    term,
    output logic signed [63:0]    acc
);
    import ats_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
            prod_reg <= op_l * op_r;
        if (ctrl.init)
            acc_reg <= term;
        else if (ctrl.acc)
            acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
    end

    assign acc = acc_reg;
endmodule

@@ hdl/ats_cordic.sv @@
// Angle reduction and iterative CORDIC sine/cosine
module ats_cordic #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);
    import ats_pkg::*;

    localparam int ZW = 62 - FRAC_BITS;
    localparam int QB = ZW - 32;
    localparam int KW = $clog2(QB);
    localparam int SH = 30 - FRAC_BITS;

    typedef enum logic [2:0] {C_IDLE, C_REDUCE, C_FOLD, C_ITER, C_DONE} cstate_t;

    cstate_t            state_reg;
    logic [ZW-1:0]      rem_reg;
    logic               neg_reg;
    logic               flip_reg;
    logic [KW-1:0]      k_reg;
    logic [4:0]         i_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [35:0] z_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic               done_reg;

    logic signed [32:0] ang_ext;
    logic [32:0]        ang_mag;
    logic [ZW-1:0]      sub_val;
    logic signed [35:0] z_base;
    logic signed [35:0] z_wrap;
    logic signed [35:0] z_fold;
    logic               fold_flip;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [35:0] atan_ext;
    logic signed [35:0] xs;
    logic signed [35:0] ys;

    always_comb
    begin
        ang_ext  = {angle[31], angle};
        ang_mag  = ang_ext[32] ? 33'(-ang_ext) : 33'(ang_ext);
        sub_val  = ZW'(TWO_PI_Q30) << k_reg;
        z_base   = neg_reg ? -$signed(rem_reg[35:0]) : $signed(rem_reg[35:0]);
        if (z_base > PI_Q30)
            z_wrap = z_base - TWO_PI_Q30;
        else if (z_base < -PI_Q30)
            z_wrap = z_base + TWO_PI_Q30;
        else
            z_wrap = z_base;
        fold_flip = 1'b1;
        if (z_wrap > HALF_PI_Q30)
            z_fold = z_wrap - PI_Q30;
        else if (z_wrap < -HALF_PI_Q30)
            z_fold = z_wrap + PI_Q30;
        else
        begin
            z_fold    = z_wrap;
            fold_flip = 1'b0;
        end
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
        atan_ext = $signed({4'b0000, atan_q30(i_reg)});
        xs       = x_reg >>> SH;
        ys       = y_reg >>> SH;
        if (flip_reg)
        begin
            xs = -xs;
            ys = -ys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            flip_reg  <= 1'b0;
            k_reg     <= '0;
            i_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            sin_reg   <= '0;
            cos_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == C_DONE);
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= ZW'(ang_mag) << SH;
                        neg_reg   <= angle[31];
                        k_reg     <= KW'(QB - 1);
                        state_reg <= C_REDUCE;
                    end
                end
                C_REDUCE:
                begin
                    if (rem_reg >= sub_val)
                        rem_reg <= rem_reg - sub_val;
                    if (k_reg == '0)
                        state_reg <= C_FOLD;
                    else
                        k_reg <= k_reg - 1'b1;
                end
                C_FOLD:
                begin
                    z_reg     <= z_fold;
                    flip_reg  <= fold_flip;
                    x_reg     <= GAIN_Q30;
                    y_reg     <= '0;
                    i_reg     <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_ext;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_ext;
                    end
                    if (i_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= C_DONE;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                C_DONE:
                begin
                    cos_reg   <= sat32({{28{xs[35]}}, xs});
                    sin_reg   <= sat32({{28{ys[35]}}, ys});
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;
endmodule

@@ hdl/affine_transform_stack.sv @@
// Top level: command sequencer, current matrix, save stack memory
// Transforms work through the shared multiplier (two products per element, then
// accumulate and store); rotate first runs the CORDIC loop for sine and cosine.
// One command at a time; the next is taken while the previous result waits.
// Reset: identity matrix, empty stack, zero offsets; stack memory is not cleared.
module affine_transform_stack #(
    parameter int STACK_DEPTH  = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ats_cmd_if.sink   cmd,
    ats_res_if.source res,
    ats_cfg_if.sink   cfg
);
    import ats_pkg::*;

    `include "affine_transform_stack_macros.svh"

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = STACK_DEPTH * 6;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] ROUND_ADD = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_MUL0, S_MUL1, S_ACC, S_STORE, S_COPY, S_PUSH, S_POP, S_FINISH
    } state_t;

    state_t             state_reg;
    logic signed [31:0] cur_reg [6];
    logic signed [31:0] new_reg [6];
    logic [LW-1:0]      lvl_reg;
    logic signed [15:0] off_x_reg;
    logic signed [15:0] off_y_reg;
    cmd_t               cmd_reg;
    logic signed [31:0] opa_reg;
    logic signed [31:0] opb_reg;
    logic [2:0]         e_reg;
    logic [2:0]         k_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic [1:0]         status_reg;
    logic               res_valid_reg;
    logic signed [15:0] res_px_reg;
    logic signed [15:0] res_py_reg;
    logic signed [31:0] res_mat_reg [6];
    logic [5:0]         res_depth_reg;
    logic [1:0]         res_status_reg;

    logic signed [31:0] stack_mem [MEM_DEPTH];
    logic signed [31:0] rd_data_reg;

    logic               accept;
    logic               row;
    logic [1:0]         col;
    logic               second;
    logic signed [31:0] m [6];
    logic signed [31:0] op_l;
    logic signed [31:0] op_r;
    logic signed [63:0] term;
    logic signed [63:0] acc;
    logic signed [63:0] trunc_v;
    mac_ctrl_t          mac_ctrl;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [31:0] sin_q;
    logic signed [31:0] cos_q;
    logic [LW-1:0]      lvl_sel;
    logic [AW-1:0]      base_addr;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic               slot_free;

    assign accept       = cmd.valid && cmd.ready;
    assign cmd.ready    = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign cordic_start = accept && (cmd_t'(cmd.command) == CMD_ROTATE);
    assign slot_free    = !res_valid_reg || res.ready;

    always_comb
    begin
        row    = e_reg[0];
        col    = e_reg[2:1];
        second = (state_reg == S_MUL1);
        case (cmd_reg)
            CMD_TRANSLATE:
            begin
                m[0] = ONE; m[1] = '0; m[2] = '0; m[3] = ONE; m[4] = opa_reg; m[5] = opb_reg;
            end
            CMD_ROTATE:
            begin
                m[0] = cos_q; m[1] = sin_q; m[2] = -sin_q; m[3] = cos_q; m[4] = '0; m[5] = '0;
            end
            CMD_SCALE:
            begin
                m[0] = opa_reg; m[1] = '0; m[2] = '0; m[3] = opb_reg; m[4] = '0; m[5] = '0;
            end
            default:
            begin
                m[0] = ONE; m[1] = opb_reg; m[2] = opa_reg; m[3] = ONE; m[4] = '0; m[5] = '0;
            end
        endcase
        op_l = cur_reg[{1'b0, second, row}];
        if (cmd_reg == CMD_POINT)
        begin
            op_r = second ? opb_reg : opa_reg;
            term = 64'(cur_reg[{2'b10, row}])
                 + (64'(row ? off_y_reg : off_x_reg) <<< FRAC_BITS);
        end
        else
        begin
            op_r = m[{col, second}];
            term = (col == 2'd2) ? 64'(cur_reg[{2'b10, row}]) : 64'sd0;
        end
        mac_ctrl.init = (state_reg == S_MUL0);
        mac_ctrl.mul  = (state_reg == S_MUL0) || (state_reg == S_MUL1);
        mac_ctrl.acc  = (state_reg == S_MUL1) || (state_reg == S_ACC);
        trunc_v = acc[63] ? ((acc + ROUND_ADD) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
        lvl_sel   = (state_reg == S_POP) ? lvl_reg - 1'b1 : lvl_reg;
        base_addr = (AW'(lvl_sel) << 2) + (AW'(lvl_sel) << 1);
        mem_addr  = base_addr + AW'(k_reg);
        mem_we    = (state_reg == S_PUSH);
    end

    ats_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_l (op_l),
        .op_r (op_r),
        .term (term),
        .acc  (acc)
    );

    ats_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cmd.operand_a),
        .done  (cordic_done),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_addr] <= cur_reg[k_reg];
        rd_data_reg <= stack_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '{ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0};
            new_reg        <= '{default: '0};
            lvl_reg        <= '0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            cmd_reg        <= CMD_IDENTITY;
            opa_reg        <= '0;
            opb_reg        <= '0;
            e_reg          <= '0;
            k_reg          <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            status_reg     <= STATUS_OK;
            res_valid_reg  <= 1'b0;
            res_px_reg     <= '0;
            res_py_reg     <= '0;
            res_mat_reg    <= '{default: '0};
            res_depth_reg  <= '0;
            res_status_reg <= STATUS_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == CFG_OFFSET_X)
                    off_x_reg <= cfg.data;
                else if (cfg.index == CFG_OFFSET_Y)
                    off_y_reg <= cfg.data;
            end
            if (res_valid_reg && res.ready && state_reg != S_FINISH)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= cmd_t'(cmd.command);
                        opa_reg    <= cmd.operand_a;
                        opb_reg    <= cmd.operand_b;
                        px_reg     <= '0;
                        py_reg     <= '0;
                        e_reg      <= '0;
                        k_reg      <= '0;
                        if (cmd_t'(cmd.command) == CMD_PUSH && lvl_reg == LW'(STACK_DEPTH))
                            status_reg <= STATUS_PUSH_FULL;
                        else if (cmd_t'(cmd.command) == CMD_POP && lvl_reg == '0)
                            status_reg <= STATUS_POP_EMPTY;
                        else
                            status_reg <= STATUS_OK;
                        case (cmd_t'(cmd.command))
                            CMD_IDENTITY:
                            begin
                                cur_reg   <= '{ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0};
                                state_reg <= S_FINISH;
                            end
                            CMD_ROTATE: state_reg <= S_CORDIC;
                            CMD_PUSH:
                            begin
                                if (lvl_reg == LW'(STACK_DEPTH))
                                    state_reg <= S_FINISH;
                                else
                                    state_reg <= S_PUSH;
                            end
                            CMD_POP:
                            begin
                                if (lvl_reg == '0)
                                    state_reg <= S_FINISH;
                                else
                                    state_reg <= S_POP;
                            end
                            default: state_reg <= S_MUL0;
                        endcase
                    end
                end
                S_CORDIC:
                begin
                    if (cordic_done)
                        state_reg <= S_MUL0;
                end
                S_MUL0: state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_ACC;
                S_ACC:  state_reg <= S_STORE;
                S_STORE:
                begin
                    if (cmd_reg == CMD_POINT)
                    begin
                        if (row)
                            py_reg <= sat16(trunc_v);
                        else
                            px_reg <= sat16(trunc_v);
                        if (e_reg == 3'd1)
                            state_reg <= S_FINISH;
                        else
                        begin
                            e_reg     <= e_reg + 1'b1;
                            state_reg <= S_MUL0;
                        end
                    end
                    else
                    begin
                        new_reg[e_reg] <= sat32(acc);
                        if (e_reg == 3'd5)
                            state_reg <= S_COPY;
                        else
                        begin
                            e_reg     <= e_reg + 1'b1;
                            state_reg <= S_MUL0;
                        end
                    end
                end
                S_COPY:
                begin
                    cur_reg   <= new_reg;
                    state_reg <= S_FINISH;
                end
                S_PUSH:
                begin
                    if (k_reg == 3'd5)
                    begin
                        lvl_reg   <= lvl_reg + 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_POP:
                begin
                    if (k_reg != 3'd0)
                        cur_reg[k_reg - 1'b1] <= rd_data_reg;
                    if (k_reg == 3'd6)
                    begin
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_px_reg     <= px_reg;
                        res_py_reg     <= py_reg;
                        res_mat_reg    <= cur_reg;
                        res_depth_reg  <= 6'(lvl_reg);
                        res_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.point_x   = res_px_reg;
    assign res.point_y   = res_py_reg;
    assign res.mat_a     = res_mat_reg[0];
    assign res.mat_b     = res_mat_reg[1];
    assign res.mat_c     = res_mat_reg[2];
    assign res.mat_d     = res_mat_reg[3];
    assign res.mat_tx    = res_mat_reg[4];
    assign res.mat_ty    = res_mat_reg[5];
    assign res.depth_now = res_depth_reg;
    assign res.status    = res_status_reg;

    `ATS_ASSERT_IMPL(a_level_bound, 1'b1, lvl_reg <= LW'(STACK_DEPTH))
    `ATS_ASSERT_NEXT(a_busy_after_accept, accept, !cmd.ready)
    `ATS_ASSERT_NEXT(a_finish_delivers, (state_reg == S_FINISH) && slot_free, res.valid)
endmodule

@@ verif/affine_transform_stack_test.sv @@
// Self-checking testbench for the affine transform stack: commands, stack, rotation, point map
module affine_transform_stack_test;
    import ats_pkg::*;

    localparam int DEPTH = 32;
    localparam int FB    = 16;
    localparam int STEPS = 16;

    typedef struct {
        cmd_t               op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } cmd_item_t;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [31:0] m[6];
        logic [5:0]         depth;
        logic [1:0]         status;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ats_cmd_if cmd_ch ();
    ats_res_if res_ch ();
    ats_cfg_if cfg_ch ();

    affine_transform_stack uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cmd_item_t pending_cmds[$];
    result_t   expected_results[$];
    int        errors = 0;
    int        results_seen = 0;
    int        cmds_sent = 0;
    bit        calm = 1'b0;

    // predictor state
    logic signed [31:0] cur_m[6];
    logic signed [31:0] saved[DEPTH][6];
    int                 level = 0;
    logic signed [15:0] off_x = 0;
    logic signed [15:0] off_y = 0;

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint qprod(logic signed [31:0] x, logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return floor_sh(p, FB);
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                          64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                          64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                          64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                          64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return t[i];
    endfunction

    task automatic sine_cosine(input logic signed [31:0] ang,
                               output logic signed [31:0] s,
                               output logic signed [31:0] c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * (64'sd1 <<< (30 - FB));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        z = z % 64'sd6746518852;
        if (z > 64'sd3373259426) z -= 64'sd6746518852;
        if (z < -64'sd3373259426) z += 64'sd6746518852;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_entry(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        x = floor_sh(x, 30 - FB);
        y = floor_sh(y, 30 - FB);
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clamp32(x);
        s = clamp32(y);
    endtask

    task automatic compose(input logic signed [31:0] t[6]);
        logic signed [31:0] r[6];
        r[0] = clamp32(qprod(cur_m[0], t[0]) + qprod(cur_m[2], t[1]));
        r[1] = clamp32(qprod(cur_m[1], t[0]) + qprod(cur_m[3], t[1]));
        r[2] = clamp32(qprod(cur_m[0], t[2]) + qprod(cur_m[2], t[3]));
        r[3] = clamp32(qprod(cur_m[1], t[2]) + qprod(cur_m[3], t[3]));
        r[4] = clamp32(qprod(cur_m[0], t[4]) + qprod(cur_m[2], t[5]) + cur_m[4]);
        r[5] = clamp32(qprod(cur_m[1], t[4]) + qprod(cur_m[3], t[5]) + cur_m[5]);
        cur_m = r;
    endtask

    function automatic logic signed [15:0] map_axis(logic signed [31:0] p,
            logic signed [31:0] q, logic signed [31:0] k0, logic signed [31:0] k1,
            logic signed [31:0] t, logic signed [15:0] off);
        longint v;
        v = qprod(k0, p) + qprod(k1, q) + longint'(t) + (longint'(off) <<< FB);
        return clamp16(v / (64'sd1 <<< FB));
    endfunction

    task automatic set_identity();
        cur_m = '{32'sh10000, 0, 0, 32'sh10000, 0, 0};
    endtask

    task automatic predict_result(input cmd_item_t it);
        result_t r;
        logic signed [31:0] t[6];
        logic signed [31:0] s, c;
        r.px = 0;
        r.py = 0;
        r.status = STATUS_OK;
        case (it.op)
            CMD_IDENTITY: set_identity();
            CMD_TRANSLATE:
            begin
                t = '{32'sh10000, 0, 0, 32'sh10000, it.a, it.b};
                compose(t);
            end
            CMD_ROTATE:
            begin
                sine_cosine(it.a, s, c);
                t = '{c, s, -s, c, 0, 0};
                compose(t);
            end
            CMD_SCALE:
            begin
                t = '{it.a, 0, 0, it.b, 0, 0};
                compose(t);
            end
            CMD_SHEAR:
            begin
                t = '{32'sh10000, it.b, it.a, 32'sh10000, 0, 0};
                compose(t);
            end
            CMD_PUSH:
                if (level < DEPTH)
                begin
                    saved[level] = cur_m;
                    level++;
                end
                else
                    r.status = STATUS_PUSH_FULL;
            CMD_POP:
                if (level > 0)
                begin
                    level--;
                    cur_m = saved[level];
                end
                else
                    r.status = STATUS_POP_EMPTY;
            default:
            begin
                r.px = map_axis(it.a, it.b, cur_m[0], cur_m[2], cur_m[4], off_x);
                r.py = map_axis(it.a, it.b, cur_m[1], cur_m[3], cur_m[5], off_y);
            end
        endcase
        r.m = cur_m;
        r.depth = level[5:0];
        expected_results.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.command   <= CMD_IDENTITY;
            cmd_ch.operand_a <= '0;
            cmd_ch.operand_b <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_result('{cmd_t'(cmd_ch.command), cmd_ch.operand_a,
                                 cmd_ch.operand_b});
                cmds_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 10))
                begin
                    cmd_item_t it;
                    it = pending_cmds.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.command   <= it.op;
                    cmd_ch.operand_a <= it.a;
                    cmd_ch.operand_b <= it.b;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            res_ch.ready <= calm || $urandom_range(99) >= 10;
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction", $time);
                end
                else
                begin
                    result_t e;
                    bit bad;
                    e = expected_results.pop_front();
                    bad = (e.px !== res_ch.point_x) || (e.py !== res_ch.point_y)
                        || (e.m[0] !== res_ch.mat_a) || (e.m[1] !== res_ch.mat_b)
                        || (e.m[2] !== res_ch.mat_c) || (e.m[3] !== res_ch.mat_d)
                        || (e.m[4] !== res_ch.mat_tx) || (e.m[5] !== res_ch.mat_ty)
                        || (e.depth !== res_ch.depth_now) || (e.status !== res_ch.status);
                    if (bad)
                    begin
                        errors++;
                        $display("%0t: expected pt %0d,%0d m %0d %0d %0d %0d %0d %0d d %0d s %0d",
                                 $time, e.px, e.py, e.m[0], e.m[1], e.m[2], e.m[3],
                                 e.m[4], e.m[5], e.depth, e.status);
                        $display("%0t: actual   pt %0d,%0d m %0d %0d %0d %0d %0d %0d d %0d s %0d",
                                 $time, res_ch.point_x, res_ch.point_y, res_ch.mat_a,
                                 res_ch.mat_b, res_ch.mat_c, res_ch.mat_d, res_ch.mat_tx,
                                 res_ch.mat_ty, res_ch.depth_now, res_ch.status);
                    end
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(32'h2_0000)) - 32'sh1_0000;
            2: return $signed($urandom_range(32'h40_0000)) - 32'sh20_0000;
            3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(32'h400_0000)) - 32'sh200_0000;
        endcase
    endfunction

    task automatic queue_cmd(cmd_t op, logic signed [31:0] a, logic signed [31:0] b);
        pending_cmds.push_back('{op, a, b});
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_offset(logic [3:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_OFFSET_X)
            off_x = val;
        else if (idx == CFG_OFFSET_Y)
            off_y = val;
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] ox[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000};
        logic [15:0] oy[4] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0000};
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_OFFSET_X;
        cfg_ch.data  = '0;
        set_identity();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(CMD_POP, 0, 0);
        queue_cmd(CMD_POINT, 32'sh7FFFFFFF, 32'sh80000000);
        queue_cmd(CMD_TRANSLATE, 32'sh0003_8000, -32'sh0002_4000);
        queue_cmd(CMD_PUSH, 0, 0);
        queue_cmd(CMD_ROTATE, 32'sh0001_921F, 0);
        queue_cmd(CMD_ROTATE, 32'sh80000000, 32'sh7FFFFFFF);
        queue_cmd(CMD_ROTATE, 32'sh7FFFFFFF, 0);
        queue_cmd(CMD_SCALE, 32'sh0002_0000, -32'sh0000_8000);
        queue_cmd(CMD_SHEAR, 32'sh0000_4000, 32'sh0001_0000);
        queue_cmd(CMD_POINT, 32'sh0010_0000, -32'sh0005_0000);
        queue_cmd(CMD_SCALE, 32'sh7FFFFFFF, 32'sh80000000);
        queue_cmd(CMD_SCALE, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_cmd(CMD_POINT, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_cmd(CMD_POP, 0, 0);
        queue_cmd(CMD_POP, 0, 0);
        queue_cmd(CMD_IDENTITY, 32'sh7FFFFFFF, 32'sh80000000);
        for (int i = 0; i < DEPTH + 2; i++)
            queue_cmd(CMD_PUSH, 0, 0);
        for (int i = 0; i < DEPTH + 2; i++)
            queue_cmd(CMD_POP, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_offset(CFG_OFFSET_X, ox[ph]);
            write_offset(CFG_OFFSET_Y, oy[ph]);
            calm = (ph == 3);
            if (ph == 3)
            begin
                write_offset(CFG_OFFSET_X, 16'($urandom));
                write_offset(CFG_OFFSET_Y, 16'($urandom));
            end
            for (int n = 0; n < 80; n++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 30)
                    queue_cmd(CMD_POINT, rand_q(), rand_q());
                else if (pick < 40)
                    queue_cmd(CMD_PUSH, rand_q(), rand_q());
                else if (pick < 50)
                    queue_cmd(CMD_POP, rand_q(), rand_q());
                else if (pick < 55)
                    queue_cmd(CMD_IDENTITY, rand_q(), rand_q());
                else
                    queue_cmd(cmd_t'($urandom_range(1, 4)), rand_q(), rand_q());
            end
            wait_drained();
        end

        $display("Ran %0d commands across four offset settings; %0d results checked.",
                 cmds_sent, results_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ affine_transform_stack.f @@
+incdir+hdl
hdl/ats_pkg.sv
hdl/ats_if.sv
hdl/ats_mac.sv
hdl/ats_cordic.sv
hdl/affine_transform_stack.sv
verif/affine_transform_stack_test.sv
